>>> design/csac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csac_pkg;

    // Field widths of the channels and of the configuration port.
    localparam int CMD_W     = 1;
    localparam int PL_W      = 8;
    localparam int BUDGET_W  = 40;
    localparam int SYMS_W    = 16;
    localparam int TIME_W    = 50;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    // Shared divider sizing.
    localparam int DIV_W     = 53;
    localparam int DIVR_W    = 20;
    localparam int DIV_CNT_W = 6;

    // Blocks numerator is at most ten bits wide.
    localparam int SYM_NUM_W = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SF       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BW       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CR       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LDRO     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 3'd6;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TIME   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

    // Low data rate optimization modes.
    localparam logic [1:0] LDRO_OFF = 2'd0;
    localparam logic [1:0] LDRO_ON  = 2'd1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYM_START,
        ST_SYM_WAIT,
        ST_MUL,
        ST_TIME_START,
        ST_TIME_WAIT,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    // Control from the sequencer to the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_ctrl_t;

endpackage

`default_nettype wire

>>> design/csac_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface csac_req_if;
    logic                          valid;
    logic                          ready;
    logic [csac_pkg::CMD_W-1:0]    command;
    logic [csac_pkg::PL_W-1:0]     payload_bytes;
    logic [csac_pkg::BUDGET_W-1:0] budget_us;

    modport source (output valid, output command, output payload_bytes,
                    output budget_us, input ready);
    modport sink   (input valid, input command, input payload_bytes,
                    input budget_us, output ready);
endinterface

`default_nettype wire

>>> design/csac_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface csac_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [csac_pkg::SYMS_W-1:0] payload_symbols;
    logic [csac_pkg::TIME_W-1:0] time_on_air_us;
    logic [csac_pkg::PL_W-1:0]   max_payload;

    modport source (output valid, output payload_symbols, output time_on_air_us,
                    output max_payload, input ready);
    modport sink   (input valid, input payload_symbols, input time_on_air_us,
                    input max_payload, output ready);
endinterface

`default_nettype wire

>>> design/csac_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring shift-and-subtract divider, one quotient bit per cycle.
// The dividend is taken MSB first; after N steps the low N bits of the
// quotient output hold the quotient of the top N dividend bits.
module csac_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire csac_pkg::div_ctrl_t           ctrl,
    input  wire logic [csac_pkg::DIV_W-1:0]    dividend,
    input  wire logic [csac_pkg::DIVR_W-1:0]   divisor,
    output logic                               done,
    output logic [csac_pkg::DIV_W-1:0]         quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [csac_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [csac_pkg::DIV_W-1:0]        sh_reg, sh_next;
    logic [csac_pkg::DIVR_W-1:0]       rem_reg, rem_next;
    logic [csac_pkg::DIVR_W-1:0]       dvs_reg, dvs_next;
    logic [csac_pkg::DIVR_W:0]         trial;
    logic [csac_pkg::DIVR_W:0]         diff;
    logic                              fits;

    // One trial subtraction of the divisor.
    assign trial = {rem_reg, sh_reg[csac_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Step control and datapath update.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ctrl.steps;
            sh_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            sh_next  = {sh_reg[csac_pkg::DIV_W-2:0], fits};
            rem_next = fits ? diff[csac_pkg::DIVR_W-1:0] : trial[csac_pkg::DIVR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == {{(csac_pkg::DIV_CNT_W-1){1'b0}}, 1'b1})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

`default_nettype wire

>>> design/chirp_spread_airtime_calculator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Fields
// req      in         command, payload_bytes, budget_us
// rsp      out        payload_symbols, time_on_air_us, max_payload
// cfg      in         cfg_wen, cfg_index, cfg_data (write only)
//
// Each evaluation uses the shared serial divider at most twice:
// 10 steps for the symbol blocks and 53 steps for the airtime.
// Command 0 is one evaluation; command 1 is a binary search of 8 evaluations.
// req.ready is high only while the sequencer is idle.
// A finished result sits in the rsp register, so the next transaction can be
// accepted while it waits. Reset restores the default radio settings.
module chirp_spread_airtime_calculator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    csac_req_if.sink                                req,
    csac_rsp_if.source                              rsp,
    input  wire logic                               cfg_wen,
    input  wire logic [csac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [csac_pkg::CFG_DAT_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [3:0]  sf_reg;
    logic [19:0] bw_reg;
    logic [3:0]  cr_reg;
    logic        hdr_reg;
    logic        crc_reg;
    logic [1:0]  ldro_reg;
    logic [15:0] pre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg   <= 4'd7;
            bw_reg   <= 20'd125000;
            cr_reg   <= 4'd5;
            hdr_reg  <= 1'b1;
            crc_reg  <= 1'b1;
            ldro_reg <= 2'd2;
            pre_reg  <= 16'd8;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                csac_pkg::CFG_SF:       sf_reg   <= cfg_data[3:0];
                csac_pkg::CFG_BW:       bw_reg   <= cfg_data[19:0];
                csac_pkg::CFG_CR:       cr_reg   <= cfg_data[3:0];
                csac_pkg::CFG_HDR:      hdr_reg  <= cfg_data[0];
                csac_pkg::CFG_CRC:      crc_reg  <= cfg_data[0];
                csac_pkg::CFG_LDRO:     ldro_reg <= cfg_data[1:0];
                csac_pkg::CFG_PREAMBLE: pre_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    csac_pkg::state_t                state_reg, state_next;
    logic [csac_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [csac_pkg::BUDGET_W-1:0]   budget_reg, budget_next;
    logic [csac_pkg::PL_W-1:0]       n_reg, n_next;
    logic [2:0]                      bitpos_reg, bitpos_next;
    logic [csac_pkg::SYMS_W-1:0]     syms_reg, syms_next;
    logic [37:0]                     prod_reg, prod_next;
    logic [csac_pkg::TIME_W-1:0]     t_reg, t_next;
    logic [csac_pkg::SYMS_W-1:0]     res_syms_reg, res_syms_next;
    logic [csac_pkg::TIME_W-1:0]     res_t_reg, res_t_next;
    logic [csac_pkg::PL_W-1:0]       res_max_reg, res_max_next;
    logic                            ovalid_reg, ovalid_next;
    logic [csac_pkg::SYMS_W-1:0]     osyms_reg, osyms_next;
    logic [csac_pkg::TIME_W-1:0]     ot_reg, ot_next;
    logic [csac_pkg::PL_W-1:0]       omax_reg, omax_next;

    // Shared divider.
    csac_pkg::div_ctrl_t             div_ctrl;
    logic [csac_pkg::DIV_W-1:0]      div_dividend;
    logic [csac_pkg::DIVR_W-1:0]     div_divisor;
    logic                            div_done;
    logic [csac_pkg::DIV_W-1:0]      div_q;

    csac_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Low data rate optimization: forced off or on by the mode, or automatic when the symbol exceeds 16 ms.
    logic [15:0] chips;
    logic [22:0] chips_x125;
    logic        ldro_auto;
    logic        ldro_on;

    assign chips      = 16'd1 << sf_reg;
    assign chips_x125 = {7'd0, chips} * 23'd125;
    assign ldro_auto  = (bw_reg != 20'd0) && (chips_x125 > {2'b00, bw_reg, 1'b0});
    assign ldro_on    = (ldro_reg == csac_pkg::LDRO_OFF) ? 1'b0 :
                        (ldro_reg == csac_pkg::LDRO_ON)  ? 1'b1 : ldro_auto;

    // Symbol formula, both sides divided by four: ceil(m / d).
    logic signed [11:0] sym_m;
    logic signed [5:0]  sym_d;
    logic [csac_pkg::SYM_NUM_W-1:0] sym_num;
    logic [13:0]        blk_mul;

    assign sym_m   = $signed({3'b000, n_reg, 1'b0}) - $signed({8'd0, sf_reg}) + 12'sd7
                   + (crc_reg ? 12'sd4 : 12'sd0) - (hdr_reg ? 12'sd0 : 12'sd5);
    assign sym_d   = $signed({2'b00, sf_reg}) - (ldro_on ? 6'sd2 : 6'sd0);
    assign sym_num = sym_m[csac_pkg::SYM_NUM_W-1:0]
                   + {6'd0, sym_d[3:0]} - {{(csac_pkg::SYM_NUM_W-1){1'b0}}, 1'b1};
    assign blk_mul = {4'd0, div_q[csac_pkg::SYM_NUM_W-1:0]} * {10'd0, cr_reg};

    // Airtime numerator in quarter symbols.
    logic [19:0] quarters;
    assign quarters = {2'b00, pre_reg, 2'b00} + 20'd17 + {2'b00, syms_reg, 2'b00};

    // Saturated airtime from the divider.
    logic [csac_pkg::TIME_W-1:0] t_sat;
    assign t_sat = (div_q[csac_pkg::DIV_W-1:csac_pkg::TIME_W] != '0) ? '1
                 : div_q[csac_pkg::TIME_W-1:0];

    logic fits;
    assign fits = (t_reg <= {10'd0, budget_reg});

    logic rsp_free;
    assign rsp_free = !ovalid_reg || rsp.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csac_pkg::ST_IDLE:
                if (req.valid)
                    state_next = csac_pkg::ST_SYM_START;
            csac_pkg::ST_SYM_START:
                if (sym_d <= 6'sd0 || sym_m <= 12'sd0)
                    state_next = csac_pkg::ST_MUL;
                else
                    state_next = csac_pkg::ST_SYM_WAIT;
            csac_pkg::ST_SYM_WAIT:
                if (div_done)
                    state_next = csac_pkg::ST_MUL;
            csac_pkg::ST_MUL:
                state_next = csac_pkg::ST_TIME_START;
            csac_pkg::ST_TIME_START:
                if (bw_reg == 20'd0)
                    state_next = csac_pkg::ST_DECIDE;
                else
                    state_next = csac_pkg::ST_TIME_WAIT;
            csac_pkg::ST_TIME_WAIT:
                if (div_done)
                    state_next = csac_pkg::ST_DECIDE;
            csac_pkg::ST_DECIDE:
                if (cmd_reg == csac_pkg::CMD_TIME || bitpos_reg == 3'd0)
                    state_next = csac_pkg::ST_FINISH;
                else
                    state_next = csac_pkg::ST_SYM_START;
            csac_pkg::ST_FINISH:
                if (rsp_free)
                    state_next = csac_pkg::ST_IDLE;
            default:
                state_next = csac_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        cmd_next      = cmd_reg;
        budget_next   = budget_reg;
        n_next        = n_reg;
        bitpos_next   = bitpos_reg;
        syms_next     = syms_reg;
        prod_next     = prod_reg;
        t_next        = t_reg;
        res_syms_next = res_syms_reg;
        res_t_next    = res_t_reg;
        res_max_next  = res_max_reg;
        ovalid_next   = ovalid_reg && !rsp.ready;
        osyms_next    = osyms_reg;
        ot_next       = ot_reg;
        omax_next     = omax_reg;
        div_ctrl      = '{start: 1'b0, steps: '0};
        div_dividend  = '0;
        div_divisor   = bw_reg;
        req.ready     = 1'b0;
        unique case (state_reg)
            csac_pkg::ST_IDLE:
            begin
                req.ready     = 1'b1;
                cmd_next      = req.command;
                budget_next   = req.budget_us;
                bitpos_next   = 3'd7;
                n_next        = (req.command == csac_pkg::CMD_SEARCH) ? 8'h80
                                                                     : req.payload_bytes;
                res_syms_next = '0;
                res_t_next    = '0;
                res_max_next  = '0;
            end
            csac_pkg::ST_SYM_START:
            begin
                syms_next = 16'd8;
                if (!(sym_d <= 6'sd0 || sym_m <= 12'sd0))
                begin
                    div_ctrl     = '{start: 1'b1,
                                     steps: csac_pkg::DIV_CNT_W'(csac_pkg::SYM_NUM_W)};
                    div_dividend = {sym_num, {(csac_pkg::DIV_W-csac_pkg::SYM_NUM_W){1'b0}}};
                    div_divisor  = {16'd0, sym_d[3:0]};
                end
            end
            csac_pkg::ST_SYM_WAIT:
                if (div_done)
                    syms_next = 16'd8 + {2'b00, blk_mul};
            csac_pkg::ST_MUL:
                prod_next = {18'd0, quarters} * 38'd250000;
            csac_pkg::ST_TIME_START:
            begin
                t_next = '0;
                if (bw_reg != 20'd0)
                begin
                    div_ctrl     = '{start: 1'b1,
                                     steps: csac_pkg::DIV_CNT_W'(csac_pkg::DIV_W)};
                    div_dividend = {15'd0, prod_reg} << sf_reg;
                end
            end
            csac_pkg::ST_TIME_WAIT:
                if (div_done)
                    t_next = t_sat;
            csac_pkg::ST_DECIDE:
            begin
                if (cmd_reg == csac_pkg::CMD_TIME)
                begin
                    res_syms_next = syms_reg;
                    res_t_next    = t_reg;
                    res_max_next  = '0;
                end
                else
                begin
                    if (fits)
                    begin
                        res_syms_next = syms_reg;
                        res_t_next    = t_reg;
                        res_max_next  = n_reg;
                    end
                    if (bitpos_reg != 3'd0)
                    begin
                        bitpos_next = bitpos_reg - 3'd1;
                        n_next      = (fits ? n_reg : res_max_reg)
                                    | (8'd1 << (bitpos_reg - 3'd1));
                    end
                end
            end
            csac_pkg::ST_FINISH:
                if (rsp_free)
                begin
                    ovalid_next = 1'b1;
                    osyms_next  = res_syms_reg;
                    ot_next     = res_t_reg;
                    omax_next   = res_max_reg;
                end
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= csac_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        budget_reg   <= budget_next;
        n_reg        <= n_next;
        bitpos_reg   <= bitpos_next;
        syms_reg     <= syms_next;
        prod_reg     <= prod_next;
        t_reg        <= t_next;
        res_syms_reg <= res_syms_next;
        res_t_reg    <= res_t_next;
        res_max_reg  <= res_max_next;
        osyms_reg    <= osyms_next;
        ot_reg       <= ot_next;
        omax_reg     <= omax_next;
    end

    // Result transaction.
    assign rsp.valid           = ovalid_reg;
    assign rsp.payload_symbols = osyms_reg;
    assign rsp.time_on_air_us  = ot_reg;
    assign rsp.max_payload     = omax_reg;

endmodule

`default_nettype wire
